// ===== rtl/msa_rle_pkg.sv =====
// Shared types and constants for the run-length image decoder.
// Used by msa_image_rle_decoder and its testbench; depends on nothing else.
package msa_rle_pkg;

   localparam int OFFSET_W = 21;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int TRK_W    = 17;
   localparam int REM_W    = 34;

   localparam logic [7:0] RUN_MARK = 8'hE5;
   localparam logic [7:0] SIG0     = 8'h0E;
   localparam logic [7:0] SIG1     = 8'h0F;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SIG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;

   // Header byte positions that carry a meaning.
   localparam logic [3:0] HB_SIG0    = 4'd0;
   localparam logic [3:0] HB_SIG1    = 4'd1;
   localparam logic [3:0] HB_SPT_HI  = 4'd2;
   localparam logic [3:0] HB_SPT_LO  = 4'd3;
   localparam logic [3:0] HB_SIDE_HI = 4'd4;
   localparam logic [3:0] HB_SIDE_LO = 4'd5;
   localparam logic [3:0] HB_TRK_HI  = 4'd8;
   localparam logic [3:0] HB_TRK_LO  = 4'd9;

   typedef enum logic [6:0] {
      PH_HEADER = 7'b0000001,
      PH_LEN    = 7'b0000010,
      PH_DATA   = 7'b0000100,
      PH_MVAL   = 7'b0001000,
      PH_MHI    = 7'b0010000,
      PH_MLO    = 7'b0100000,
      PH_HALT   = 7'b1000000
   } phase_type;

   typedef enum logic [4:0] {
      SQ_IDLE = 5'b00001,
      SQ_M1   = 5'b00010,
      SQ_M2   = 5'b00100,
      SQ_M3   = 5'b01000,
      SQ_M4   = 5'b10000
   } seq_type;

endpackage

// ===== rtl/msa_rle_mul.sv =====
// Shared multiplier with a registered product, reused for every header product.
// Self-contained; the operand widths come in as parameters.
module msa_rle_mul #(
   parameter int A_W = 25,
   parameter int B_W = 17
) (
   input  logic               clock,
   input  logic               load,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic [A_W+B_W-1:0] product
);

   logic [A_W+B_W-1:0] product_ff;
   logic [A_W+B_W-1:0] product_in;

   assign product_in = (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/msa_image_rle_decoder.sv =====
// Top level of the run-length compressed disk image decoder.
// Depends on msa_rle_pkg and msa_rle_mul.
//
// The decoder takes the compressed image file one byte per word and gives one
// result word for each literal or run: value, repeat count and flat offset,
// with status and tlast. The input is held off after the last header byte,
// while the image capacity and the track total are formed by four passes
// through one shared multiplier. The input is also held off while a result
// word waits and is not being taken in the same cycle.
module msa_image_rle_decoder
   import msa_rle_pkg::*;
#(
   parameter int IMAGE_BYTES  = 2097152,
   parameter int SECTOR_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] fill_value, [23:8] repeat_count,
                                    // [44:24] out_offset, [46:45] status
   output logic        rsp_tlast    // last
);

   localparam int CAP_W = $clog2(IMAGE_BYTES + 1);
   localparam int SB_W  = $clog2(65535 * SECTOR_BYTES + 1);
   localparam int MA_W  = (CAP_W > TRK_W) ? CAP_W : TRK_W;
   localparam int P_W   = MA_W + TRK_W;
   localparam int SUM_W = ((CAP_W > COUNT_W) ? CAP_W : COUNT_W) + 1;
   localparam int EXT_W = (CAP_W > OFFSET_W) ? CAP_W : OFFSET_W;

   phase_type            phase_ff, phase_in;
   seq_type              seq_ff, seq_in;
   logic [3:0]           idx_ff, idx_in;
   logic [15:0]          spt_ff, spt_in;
   logic [TRK_W-1:0]     sides_ff, sides_in;
   logic [TRK_W-1:0]     tc_ff, tc_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [15:0]          tlen_ff, tlen_in;
   logic [15:0]          seen_ff, seen_in;
   logic                 raw_ff, raw_in;
   logic [7:0]           rv_ff, rv_in;
   logic [7:0]           rh_ff, rh_in;
   logic [CAP_W-1:0]     woff_ff, woff_in;
   logic [SB_W-1:0]      sb_ff, sb_in;

   logic                 rsp_valid_ff;
   logic [7:0]           rsp_val_ff;
   logic [COUNT_W-1:0]   rsp_cnt_ff;
   logic [OFFSET_W-1:0]  rsp_off_ff;
   logic [STATUS_W-1:0]  rsp_st_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic [7:0]           in_b;
   phase_type            ph;
   logic [3:0]           idx;
   logic [CAP_W-1:0]     woff;

   logic                 res_fire;
   logic [7:0]           res_val;
   logic [COUNT_W-1:0]   res_cnt;
   logic [CAP_W-1:0]     res_off;
   logic [STATUS_W-1:0]  res_st;
   logic                 res_last;
   logic                 chk_close;
   logic [REM_W-1:0]     rem_dec;
   logic [15:0]          tlen_new;
   logic [COUNT_W-1:0]   run_len;
   logic [SUM_W-1:0]     run_end;
   logic [EXT_W-1:0]     off_ext;

   logic                 mul_load;
   logic [MA_W-1:0]      mul_a;
   logic [TRK_W-1:0]     mul_b;
   logic [P_W-1:0]       mul_p;
   logic [CAP_W-1:0]     mul_sat;

   assign req_tready = (seq_ff == SQ_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign in_b       = req_tdata;

   // Saturating the partial capacity keeps every product within the multiplier
   // and gives the same clamped result as the full product.
   assign mul_sat = (mul_p > P_W'(IMAGE_BYTES)) ? CAP_W'(IMAGE_BYTES) : mul_p[CAP_W-1:0];

   always_comb begin
      mul_load = 1'b1;
      mul_a    = MA_W'(spt_ff);
      mul_b    = TRK_W'(SECTOR_BYTES);
      case (seq_ff)
         SQ_IDLE: begin
            mul_load = accept;
         end
         SQ_M1: begin
            mul_a = MA_W'(mul_sat);
            mul_b = tc_ff + TRK_W'(1);
         end
         SQ_M2: begin
            mul_a = MA_W'(mul_sat);
            mul_b = sides_ff;
         end
         SQ_M3: begin
            mul_a = MA_W'(tc_ff);
            mul_b = sides_ff;
         end
         default: begin
            mul_load = 1'b0;
         end
      endcase
   end

   msa_rle_mul #(
      .A_W (MA_W),
      .B_W (TRK_W)
   ) u_mul (
      .clock   (clock),
      .load    (mul_load),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   always_comb begin
      ph   = phase_ff;
      idx  = idx_ff;
      woff = woff_ff;
      if (req_tuser[0]) begin
         ph   = PH_HEADER;
         idx  = '0;
         woff = '0;
      end

      phase_in  = phase_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      spt_in    = spt_ff;
      sides_in  = sides_ff;
      tc_in     = tc_ff;
      cap_in    = cap_ff;
      rem_in    = rem_ff;
      tlen_in   = tlen_ff;
      seen_in   = seen_ff;
      raw_in    = raw_ff;
      rv_in     = rv_ff;
      rh_in     = rh_ff;
      woff_in   = woff_ff;
      sb_in     = sb_ff;
      res_fire  = 1'b0;
      res_val   = '0;
      res_cnt   = '0;
      res_off   = '0;
      res_st    = ST_OK;
      res_last  = 1'b0;
      chk_close = 1'b0;
      rem_dec   = '0;
      tlen_new  = {tlen_ff[15:8], in_b};
      run_len   = {rh_ff, in_b};
      run_end   = SUM_W'(woff) + SUM_W'(run_len);

      case (seq_ff)
         SQ_M1: begin
            sb_in  = mul_p[SB_W-1:0];
            seq_in = SQ_M2;
         end
         SQ_M2: begin
            seq_in = SQ_M3;
         end
         SQ_M3: begin
            cap_in = mul_sat;
            seq_in = SQ_M4;
         end
         SQ_M4: begin
            rem_in = mul_p[REM_W-1:0];
            seq_in = SQ_IDLE;
         end
         default: begin
         end
      endcase

      if (accept) begin
         phase_in = ph;
         idx_in   = idx;
         woff_in  = woff;
         case (ph)
            PH_HEADER: begin
               idx_in = idx + 4'd1;
               case (idx)
                  HB_SIG0: begin
                     if (in_b != SIG0) begin
                        res_fire = 1'b1;
                        res_st   = ST_BAD_SIG;
                        res_last = 1'b1;
                        phase_in = PH_HALT;
                     end
                  end
                  HB_SIG1: begin
                     if (in_b != SIG1) begin
                        res_fire = 1'b1;
                        res_st   = ST_BAD_SIG;
                        res_last = 1'b1;
                        phase_in = PH_HALT;
                     end
                  end
                  HB_SPT_HI:  spt_in   = {in_b, 8'h00};
                  HB_SPT_LO:  spt_in   = {spt_ff[15:8], in_b};
                  HB_SIDE_HI: sides_in = {1'b0, in_b, 8'h00};
                  HB_SIDE_LO: sides_in = {1'b0, sides_ff[15:8], in_b} + TRK_W'(1);
                  HB_TRK_HI:  tc_in    = {1'b0, in_b, 8'h00};
                  HB_TRK_LO: begin
                     tc_in    = {1'b0, tc_ff[15:8], in_b} + TRK_W'(1);
                     phase_in = PH_LEN;
                     idx_in   = '0;
                     seq_in   = SQ_M1;
                  end
                  default: begin
                  end
               endcase
            end
            PH_LEN: begin
               if (idx == 4'd0) begin
                  tlen_in = {in_b, 8'h00};
                  idx_in  = 4'd1;
               end else begin
                  tlen_in   = tlen_new;
                  idx_in    = '0;
                  seen_in   = '0;
                  raw_in    = ({{(SB_W-16){1'b0}}, tlen_new} == sb_ff);
                  phase_in  = PH_DATA;
                  chk_close = 1'b1;
               end
            end
            PH_DATA: begin
               seen_in = seen_ff + 16'd1;
               if (raw_ff || in_b != RUN_MARK) begin
                  if (woff >= cap_ff) begin
                     res_fire = 1'b1;
                     res_st   = ST_CORRUPT;
                     res_last = 1'b1;
                     phase_in = PH_HALT;
                  end else begin
                     res_fire  = 1'b1;
                     res_val   = in_b;
                     res_cnt   = COUNT_W'(1);
                     res_off   = woff;
                     woff_in   = woff + CAP_W'(1);
                     chk_close = 1'b1;
                  end
               end else if (({2'b00, seen_in} + 18'd3) > {2'b00, tlen_ff}) begin
                  // A run marker needs three more bytes inside its track.
                  res_fire = 1'b1;
                  res_st   = ST_CORRUPT;
                  res_last = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_MVAL;
               end
            end
            PH_MVAL: begin
               seen_in  = seen_ff + 16'd1;
               rv_in    = in_b;
               phase_in = PH_MHI;
            end
            PH_MHI: begin
               seen_in  = seen_ff + 16'd1;
               rh_in    = in_b;
               phase_in = PH_MLO;
            end
            PH_MLO: begin
               seen_in = seen_ff + 16'd1;
               if (run_end > SUM_W'(cap_ff)) begin
                  res_fire = 1'b1;
                  res_st   = ST_CORRUPT;
                  res_last = 1'b1;
                  phase_in = PH_HALT;
               end else begin
                  res_fire  = 1'b1;
                  res_val   = rv_ff;
                  res_cnt   = run_len;
                  res_off   = woff;
                  woff_in   = run_end[CAP_W-1:0];
                  phase_in  = PH_DATA;
                  chk_close = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (chk_close && (seen_in >= tlen_in)) begin
            rem_dec = rem_ff - REM_W'(rem_ff != '0);
            rem_in  = rem_dec;
            if (rem_dec == '0) begin
               // End of image: flag the data word, or give an end word of its own.
               phase_in = PH_HALT;
               res_last = 1'b1;
               if (!res_fire) begin
                  res_fire = 1'b1;
                  res_off  = woff_in;
               end
            end else begin
               phase_in = PH_LEN;
               idx_in   = '0;
            end
         end
      end
   end

   assign off_ext = EXT_W'(res_off);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         seq_ff       <= SQ_IDLE;
         idx_ff       <= '0;
         spt_ff       <= '0;
         sides_ff     <= '0;
         tc_ff        <= '0;
         cap_ff       <= '0;
         rem_ff       <= '0;
         tlen_ff      <= '0;
         seen_ff      <= '0;
         raw_ff       <= 1'b0;
         rv_ff        <= '0;
         rh_ff        <= '0;
         woff_ff      <= '0;
         sb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         seq_ff   <= seq_in;
         idx_ff   <= idx_in;
         spt_ff   <= spt_in;
         sides_ff <= sides_in;
         tc_ff    <= tc_in;
         cap_ff   <= cap_in;
         rem_ff   <= rem_in;
         tlen_ff  <= tlen_in;
         seen_ff  <= seen_in;
         raw_ff   <= raw_in;
         rv_ff    <= rv_in;
         rh_ff    <= rh_in;
         woff_ff  <= woff_in;
         sb_ff    <= sb_in;
         if (accept && res_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_fire) begin
         rsp_val_ff  <= res_val;
         rsp_cnt_ff  <= res_cnt;
         rsp_off_ff  <= off_ext[OFFSET_W-1:0];
         rsp_st_ff   <= res_st;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_st_ff, rsp_off_ff, rsp_cnt_ff, rsp_val_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != ST_OK) |-> rsp_last_ff)
      else $error("error word without tlast");

   a_last_halts: assert property (@(posedge clock) disable iff (reset)
      (accept && res_fire && res_last) |=> (phase_ff == PH_HALT))
      else $error("parser still running after a final word");

   a_offset_in_cap: assert property (@(posedge clock) disable iff (reset)
      woff_ff <= cap_ff)
      else $error("write offset beyond image capacity");

   a_cap_clamped: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(cap_ff) <= CAP_W'(IMAGE_BYTES))
      else $error("image capacity above clamp");

   a_seq_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (accept && seq_in == SQ_M1) |=> (!req_tready ##3 !req_tready))
      else $error("input taken during header arithmetic");

endmodule
